FILE: hw/rtl/itar_pkg.sv
`timescale 1ns / 1ps

package itar_pkg;

    localparam int VALUE_WIDTH = 64;
    localparam int CNT_W       = $clog2(VALUE_WIDTH);
    localparam int RADIX_W     = 6;
    localparam int DIGIT_W     = 6;
    localparam int CHAR_W      = 7;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;
    localparam logic [DIGIT_W-1:0] DIGIT_MAX_DEC = 6'd9;
    localparam logic [CHAR_W-1:0]  DIGIT_LETTER_OFS = 7'd10;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_A     = 7'h61;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DIV  = 6'b000010,
        S_SIGN = 6'b000100,
        S_RD   = 6'b001000,
        S_LOAD = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        dx = {1'b0, d};
        if (d > DIGIT_MAX_DEC)
            return CHAR_A + dx - DIGIT_LETTER_OFS;
        return CHAR_ZERO + dx;
    endfunction

endpackage

FILE: hw/rtl/itar_ram.sv
`timescale 1ns / 1ps

module itar_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/integer_to_ascii_radix_top.sv
`timescale 1ns / 1ps

// Converts one VALUE_WIDTH-bit number per input transaction into its ASCII digits in base
// 2..36 (out-of-range bases clamp to 2 or 36), most significant first, last set on the
// final character; signed base-10 negatives get a leading '-'. One number at a time:
// in_stall is high from acceptance until the last character is taken. A bit-serial
// restoring divider produces one digit per division pass, least significant
// first, into a small digit RAM; the digits are then read back in reverse, each through
// the states S_RD (RAM read), S_LOAD (character register) and S_OUT, after an S_SIGN
// step that emits the '-' for a negative number.
module integer_to_ascii_radix_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [63:0]                       value,
    input  logic [itar_pkg::RADIX_W-1:0]      radix,
    input  logic                              is_signed,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [itar_pkg::CHAR_W-1:0]       character,
    output logic                              last
);

    localparam int VW = itar_pkg::VALUE_WIDTH;

    itar_pkg::state_t state_reg, state_next;

    logic [VW-1:0]                     quot_reg, quot_next;
    logic [itar_pkg::DIGIT_W-1:0]      rem_reg, rem_next;
    logic [itar_pkg::RADIX_W-1:0]      base_reg, base_next;
    logic                              neg_reg, neg_next;
    logic [itar_pkg::CNT_W-1:0]        bit_cnt_reg, bit_cnt_next;
    logic [itar_pkg::CNT_W-1:0]        dig_cnt_reg, dig_cnt_next;
    logic [itar_pkg::CNT_W-1:0]        idx_reg, idx_next;
    logic [itar_pkg::CHAR_W-1:0]       char_reg, char_next;
    logic                              last_reg, last_next;

    logic                              in_xact;
    logic                              out_xact;
    logic [itar_pkg::RADIX_W-1:0]      base_clamp;
    logic [VW-1:0]                     in_val;
    logic                              in_neg;
    logic [itar_pkg::DIGIT_W:0]        trial;
    logic [itar_pkg::DIGIT_W:0]        diff;
    logic                              ge;
    logic [itar_pkg::DIGIT_W-1:0]      rem_new;
    logic [VW-1:0]                     quot_new;
    logic                              ram_wr;
    logic [itar_pkg::DIGIT_W-1:0]      ram_rd_data;

    assign in_xact  = in_valid && !in_stall;
    assign out_xact = out_valid && !out_stall;

    always_comb
    begin
        priority if (radix < itar_pkg::RADIX_MIN)
            base_clamp = itar_pkg::RADIX_MIN;
        else if (radix > itar_pkg::RADIX_MAX)
            base_clamp = itar_pkg::RADIX_MAX;
        else
            base_clamp = radix;
    end

    assign in_val = value[VW-1:0];
    assign in_neg = is_signed && (base_clamp == itar_pkg::RADIX_DEC) && in_val[VW-1];

    // one quotient bit per cycle
    assign trial    = {rem_reg, quot_reg[VW-1]};
    assign ge       = trial >= {1'b0, base_reg};
    assign diff     = trial - {1'b0, base_reg};
    assign rem_new  = ge ? diff[itar_pkg::DIGIT_W-1:0] : trial[itar_pkg::DIGIT_W-1:0];
    assign quot_new = {quot_reg[VW-2:0], ge};
    assign ram_wr   = (state_reg == itar_pkg::S_DIV) && (bit_cnt_reg == '0);

    always_comb
    begin
        state_next   = state_reg;
        quot_next    = quot_reg;
        rem_next     = rem_reg;
        base_next    = base_reg;
        neg_next     = neg_reg;
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        idx_next     = idx_reg;
        char_next    = char_reg;
        last_next    = last_reg;
        unique case (state_reg)
            itar_pkg::S_IDLE:
            begin
                if (in_xact)
                begin
                    quot_next    = in_neg ? (~in_val + 1'b1) : in_val;
                    rem_next     = '0;
                    base_next    = base_clamp;
                    neg_next     = in_neg;
                    bit_cnt_next = itar_pkg::CNT_W'(VW - 1);
                    dig_cnt_next = '0;
                    state_next   = itar_pkg::S_DIV;
                end
            end
            itar_pkg::S_DIV:
            begin
                quot_next    = quot_new;
                rem_next     = rem_new;
                bit_cnt_next = bit_cnt_reg - 1'b1;
                if (bit_cnt_reg == '0)
                begin
                    // digit done: restart on the quotient or start emitting
                    rem_next     = '0;
                    bit_cnt_next = itar_pkg::CNT_W'(VW - 1);
                    dig_cnt_next = dig_cnt_reg + 1'b1;
                    if (quot_new == '0)
                    begin
                        idx_next   = dig_cnt_reg;
                        state_next = neg_reg ? itar_pkg::S_SIGN : itar_pkg::S_RD;
                    end
                end
            end
            itar_pkg::S_SIGN:
            begin
                char_next  = itar_pkg::CHAR_MINUS;
                last_next  = 1'b0;
                state_next = itar_pkg::S_OUT;
            end
            itar_pkg::S_RD:
            begin
                state_next = itar_pkg::S_LOAD;
            end
            itar_pkg::S_LOAD:
            begin
                char_next  = itar_pkg::digit_char(ram_rd_data);
                last_next  = (idx_reg == '0);
                idx_next   = idx_reg - 1'b1;
                state_next = itar_pkg::S_OUT;
            end
            itar_pkg::S_OUT:
            begin
                if (out_xact)
                begin
                    state_next = last_reg ? itar_pkg::S_IDLE : itar_pkg::S_RD;
                end
            end
            default:
            begin
                state_next = itar_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= itar_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg    <= quot_next;
        rem_reg     <= rem_next;
        base_reg    <= base_next;
        neg_reg     <= neg_next;
        bit_cnt_reg <= bit_cnt_next;
        dig_cnt_reg <= dig_cnt_next;
        idx_reg     <= idx_next;
        char_reg    <= char_next;
        last_reg    <= last_next;
    end

    itar_ram #(
        .WIDTH (itar_pkg::DIGIT_W),
        .DEPTH (VW)
    ) u_digit_ram (
        .clk     (clk),
        .wr_en   (ram_wr),
        .wr_addr (dig_cnt_reg),
        .wr_data (rem_new),
        .rd_addr (idx_reg),
        .rd_data (ram_rd_data)
    );

    assign in_stall  = (state_reg != itar_pkg::S_IDLE);
    assign out_valid = (state_reg == itar_pkg::S_OUT);
    assign character = char_reg;
    assign last      = last_reg;

    a_accept_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        in_xact |=> (state_reg == itar_pkg::S_DIV))
        else $error("accepted transaction did not start division");

    a_rem_below_base: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == itar_pkg::S_DIV) |-> (rem_reg < base_reg))
        else $error("partial remainder not below base");

    a_base_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == itar_pkg::S_DIV) |->
            (base_reg >= itar_pkg::RADIX_MIN && base_reg <= itar_pkg::RADIX_MAX))
        else $error("base out of range");

    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && character == itar_pkg::CHAR_MINUS) |-> !last)
        else $error("minus sign marked as last character");

    a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_xact && last) |=> (state_reg == itar_pkg::S_IDLE))
        else $error("did not return to idle after last character");

endmodule

FILE: tb/integer_to_ascii_radix_top_tb.sv
`timescale 1ns / 1ps

module integer_to_ascii_radix_top_tb;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 300;
    localparam int RANDOM_ITEMS   = 400;
    localparam int CALM_ITEMS     = 60;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [itar_pkg::CHAR_W-1:0] code;
        logic                        final_char;
    } ascii_char_t;

    class digit_scoreboard;
        ascii_char_t expected_chars[$];
        int unsigned failures;

        function new();
            failures = 0;
        endfunction

        // expands one number into the characters the block should emit
        function void note_number(logic [63:0] raw, logic [itar_pkg::RADIX_W-1:0] rdx,
                                  logic sgn);
            logic [itar_pkg::VALUE_WIDTH-1:0] mag;
            logic [itar_pkg::VALUE_WIDTH-1:0] base;
            logic [itar_pkg::DIGIT_W-1:0]     d;
            logic [itar_pkg::CHAR_W-1:0]      digits[$];
            ascii_char_t                      entry;
            bit                               neg;
            mag = raw[itar_pkg::VALUE_WIDTH-1:0];
            if (rdx < itar_pkg::RADIX_MIN)
                base = itar_pkg::VALUE_WIDTH'(itar_pkg::RADIX_MIN);
            else if (rdx > itar_pkg::RADIX_MAX)
                base = itar_pkg::VALUE_WIDTH'(itar_pkg::RADIX_MAX);
            else
                base = itar_pkg::VALUE_WIDTH'(rdx);
            // only base 10 gets a sign, other bases format the raw pattern
            neg = sgn && (base == itar_pkg::VALUE_WIDTH'(itar_pkg::RADIX_DEC)) &&
                  mag[itar_pkg::VALUE_WIDTH-1];
            if (neg)
                mag = -mag;
            // do-while so that zero still gives one digit
            do
            begin
                d = itar_pkg::DIGIT_W'(mag % base);
                if (d > 6'd9)
                    digits.push_front(itar_pkg::CHAR_A + itar_pkg::CHAR_W'(d - 6'd10));
                else
                    digits.push_front(itar_pkg::CHAR_ZERO + itar_pkg::CHAR_W'(d));
                mag = mag / base;
            end
            while (mag != 0);
            if (neg)
                digits.push_front(itar_pkg::CHAR_MINUS);
            foreach (digits[i])
            begin
                entry.code       = digits[i];
                entry.final_char = (i == digits.size() - 1);
                expected_chars.push_back(entry);
            end
        endfunction

        function void check_char(logic [itar_pkg::CHAR_W-1:0] code, logic final_char);
            ascii_char_t want;
            if (expected_chars.size() == 0)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("unexpected character %h last %b", code, final_char);
            end
            else
            begin
                want = expected_chars.pop_front();
                if (want.code !== code || want.final_char !== final_char)
                begin
                    failures++;
                    if (failures <= MAX_REPORTS)
                        $display("character mismatch: expected %h last %b, got %h last %b",
                                 want.code, want.final_char, code, final_char);
                end
            end
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic [63:0]                   value;
    logic [itar_pkg::RADIX_W-1:0]  radix;
    logic                          is_signed;
    logic                          out_valid;
    logic                          out_stall;
    logic [itar_pkg::CHAR_W-1:0]   character;
    logic                          last;

    bit                            idling;
    digit_scoreboard               board;

    integer_to_ascii_radix_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .radix     (radix),
        .is_signed (is_signed),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .character (character),
        .last      (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // presents one number and returns once the transaction is taken, valid left high
    task automatic send_number(logic [63:0] v, logic [itar_pkg::RADIX_W-1:0] r, logic s);
        if (idling && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        value     <= v;
        radix     <= r;
        is_signed <= s;
        do
            @(posedge clk);
        while (in_stall);
        board.note_number(v, r, s);
    endtask

    // output side: checks each character transaction and stalls in bursts
    initial
    begin
        int unsigned hold;
        hold      = 0;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                board.check_char(character, last);
            if (hold != 0)
            begin
                hold--;
                out_stall <= 1'b1;
            end
            else if (idling && $urandom_range(0, 4) == 0)
            begin
                hold = $urandom_range(0, 9);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("integer_to_ascii_radix_top regression: fail");
        $finish;
    end

    initial
    begin
        logic [63:0]                  v;
        logic [itar_pkg::RADIX_W-1:0] r;
        board     = new();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        value     = '0;
        radix     = itar_pkg::RADIX_DEC;
        is_signed = 1'b0;
        idling    = 1'b1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // zero in several modes, including signed zero, then the digit boundaries 9, 10 and 35
        send_number(64'd0, itar_pkg::RADIX_DEC, 1'b0);
        send_number(64'd0, itar_pkg::RADIX_DEC, 1'b1);
        send_number(64'd0, itar_pkg::RADIX_MIN, 1'b1);
        send_number(64'd9, itar_pkg::RADIX_DEC, 1'b0);
        send_number(64'd10, itar_pkg::RADIX_DEC, 1'b0);
        send_number(64'd35, itar_pkg::RADIX_MAX, 1'b0);
        // widest values in each base extreme, then signed edge cases and other bases
        send_number('1, itar_pkg::RADIX_MIN, 1'b0);
        send_number('1, itar_pkg::RADIX_MAX, 1'b0);
        send_number('1, itar_pkg::RADIX_DEC, 1'b0);
        send_number('1, itar_pkg::RADIX_DEC, 1'b1);
        send_number('1, 6'd16, 1'b1);
        send_number(64'h8000_0000_0000_0000, itar_pkg::RADIX_DEC, 1'b1);
        send_number(64'h8000_0000_0000_0000, itar_pkg::RADIX_DEC, 1'b0);
        send_number(64'h7fff_ffff_ffff_ffff, itar_pkg::RADIX_DEC, 1'b1);
        send_number(-64'd12345, itar_pkg::RADIX_DEC, 1'b1);
        send_number(-64'd12345, 6'd8, 1'b1);
        send_number(64'h0123_4567_89ab_cdef, 6'd16, 1'b0);
        send_number(64'hfedc_ba98_7654_3210, 6'd3, 1'b0);
        // out-of-range bases clamp to 2 or 36
        send_number(64'd1000, 6'd0, 1'b0);
        send_number(64'd1000, 6'd1, 1'b1);
        send_number(64'd123456789, 6'd37, 1'b0);
        send_number('1, 6'd63, 1'b1);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 50 == 0)
                idling = ($urandom_range(0, 3) != 0);
            if (i >= RANDOM_ITEMS - CALM_ITEMS)
                idling = 1'b0;
            case ($urandom_range(0, 4))
                0: v = {$urandom, $urandom};
                1: v = 64'($urandom_range(0, 1000));
                2: v = -64'($urandom_range(1, 1000));
                3: v = {$urandom, $urandom} >> $urandom_range(0, 63);
                default: v = (64'd1 << $urandom_range(0, 63)) - 64'($urandom_range(0, 1));
            endcase
            case ($urandom_range(0, 7))
                0, 1: r = itar_pkg::RADIX_DEC;
                2: r = itar_pkg::RADIX_W'($urandom_range(0, 63));
                default: r = itar_pkg::RADIX_W'($urandom_range(2, 36));
            endcase
            send_number(v, r, 1'($urandom_range(0, 1)));
        end
        in_valid <= 1'b0;

        while (board.expected_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.failures == 0)
            $display("integer_to_ascii_radix_top regression: pass");
        else
            $display("integer_to_ascii_radix_top regression: fail");
        $finish;
    end

endmodule
